// ===== rtl/bgni_pkg.sv =====
// types and constants of the binned grid neighbor indexer
// used by bgni_div and binned_grid_neighbor_indexer; no dependencies
package bgni_pkg;

  localparam int unsigned RowW   = 12;
  localparam int unsigned BaseW  = 26;
  localparam int unsigned CountW = 14;
  localparam int unsigned IdxW   = 27;
  localparam int unsigned ProdW  = BaseW + CountW;   // offset magnitude times count
  localparam int unsigned NumW   = ProdW + 2;        // 2*prod + count
  localparam int unsigned DenW   = CountW + 1;       // 2*count
  localparam int unsigned SumW   = NumW + 2;         // signed working width of an index

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ABORT = 2'd1,
    ST_EDGE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTER,
    S_MUL,
    S_DIV,
    S_ADD,
    S_EMIT
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [RowW-1:0]    row;
    logic [BaseW-1:0]   load_base;
    logic [CountW-1:0]  load_count;
    logic [BaseW-1:0]   query_bin;
  } item_t;

  typedef struct packed {
    logic signed [IdxW-1:0] neighbor_index;
    logic [2:0]             grid_row;
    logic [2:0]             grid_col;
    logic                   in_center;
    status_e                status;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [BaseW-1:0]  base;
    logic [CountW-1:0] count;
  } row_entry_t;

endpackage

// ===== rtl/bgni_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on bgni_pkg
module bgni_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bgni_pkg::NumW-1:0]   dividend_i,
  input  logic [bgni_pkg::DenW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [bgni_pkg::NumW-1:0]   quotient_o
);

  localparam int unsigned CntW = $clog2(bgni_pkg::NumW + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [bgni_pkg::DenW-1:0]   rem_q;
  logic [bgni_pkg::DenW-1:0]   den_q;
  logic [bgni_pkg::NumW-1:0]   nq_q;
  logic [bgni_pkg::DenW:0]     rem_sh;
  logic                        ge;

  assign rem_sh = {rem_q, nq_q[bgni_pkg::NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(bgni_pkg::NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? bgni_pkg::DenW'(rem_sh - {1'b0, den_q}) : rem_sh[bgni_pkg::DenW-1:0];
      nq_q  <= {nq_q[bgni_pkg::NumW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = nq_q;

endmodule

// ===== rtl/binned_grid_neighbor_indexer.sv =====
// binned grid neighbor indexer: row table in one memory, sequencer and output register
// depends on bgni_pkg and bgni_div
//
//  channel  | ports                              | word
//  ---------+------------------------------------+---------------------------
//  item in  | start_i, busy_o, item_i            | bgni_pkg::item_t
//  result   | result_valid_o, result_o           | bgni_pkg::result_t
//
// a load writes the table in the cycle it is accepted. a query runs the one-bit-per-cycle
// divider once per neighbor row, GS = 2*SPAN_RADIUS+1 rows. a query near the table edge answers
// in the cycle after it is accepted. results leave one per cycle within a row, held while the
// divider runs, via an output register that holds the final word while the next item is taken.
// reset clears control state only; the table is undefined until loaded.
module binned_grid_neighbor_indexer #(
  parameter int unsigned ROW_COUNT   = 4096,
  parameter int unsigned SPAN_RADIUS = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  bgni_pkg::item_t     item_i,
  output logic                result_valid_o,
  output bgni_pkg::result_t   result_o
);

  localparam int unsigned AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned GS = 2 * SPAN_RADIUS + 1;
  localparam int unsigned RW = 18;
  localparam int unsigned SW = bgni_pkg::SumW;

  bgni_pkg::row_entry_t mem [ROW_COUNT];
  bgni_pkg::row_entry_t rdata_q;
  logic                 rd_en;
  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  bgni_pkg::state_e state_q, state_d;
  logic [bgni_pkg::RowW-1:0]   row_q, row_d;
  logic [bgni_pkg::BaseW-1:0]  bin_q, bin_d;
  logic [bgni_pkg::BaseW-1:0]  mag_q, mag_d;
  logic                        neg_q, neg_d;
  logic [bgni_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [bgni_pkg::BaseW-1:0]  basen_q, basen_d;
  logic signed [SW-1:0]        sbase_q, sbase_d;
  logic [2:0]                  i_q, i_d;
  logic [2:0]                  j_q, j_d;
  bgni_pkg::result_t           out_q, out_d;
  logic                        valid_q, valid_d;

  logic                          div_start;
  logic                          div_done;
  logic [bgni_pkg::NumW-1:0]     dividend;
  logic [bgni_pkg::NumW-1:0]     quotient;
  logic [bgni_pkg::ProdW-1:0]    prod;
  logic [RW-1:0]                 row_ext;
  logic [RW-1:0]                 nr;
  logic [bgni_pkg::IdxW:0]       off;
  logic signed [SW-1:0]          qs;
  logic signed [SW-1:0]          idx;
  logic                          near_edge;
  logic                          accept;

  // table: one write or one read per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{base: item_i.load_base, count: item_i.load_count};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  bgni_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  ({cnt_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign accept    = start_i && (state_q == bgni_pkg::S_IDLE);
  assign row_ext   = RW'(item_i.row);
  assign near_edge = (row_ext < RW'(SPAN_RADIUS)) || (row_ext + RW'(SPAN_RADIUS) >= RW'(ROW_COUNT));
  assign wr_addr   = row_ext[AW-1:0];
  assign prod      = mag_q * rdata_q.count;
  assign dividend  = {prod, 1'b0} + bgni_pkg::NumW'(cnt_q);
  assign off       = {2'b00, bin_q} - {2'b00, rdata_q.base};
  assign qs        = (cnt_q == '0) ? '0 :
                     (neg_q ? -$signed(SW'(quotient)) : $signed(SW'(quotient)));
  assign idx       = sbase_q + $signed(SW'(j_q)) - $signed(SW'(SPAN_RADIUS + 1));

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    bin_d     = bin_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    basen_d   = basen_q;
    sbase_d   = sbase_q;
    i_d       = i_q;
    j_d       = j_q;
    out_d     = out_q;
    valid_d   = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    nr        = '0;

    case (state_q)
      bgni_pkg::S_IDLE: begin
        if (accept) begin
          if (item_i.op == bgni_pkg::OP_LOAD) begin
            wr_en = row_ext < RW'(ROW_COUNT);
          end else if (near_edge) begin
            out_d   = '{neighbor_index: '0, grid_row: '0, grid_col: '0, in_center: 1'b0,
                        status: bgni_pkg::ST_EDGE, last: 1'b1};
            valid_d = 1'b1;
          end else begin
            row_d   = item_i.row;
            bin_d   = item_i.query_bin;
            i_d     = '0;
            j_d     = '0;
            nr      = row_ext;
            rd_en   = 1'b1;
            state_d = bgni_pkg::S_CENTER;
          end
        end
      end
      bgni_pkg::S_CENTER: begin
        neg_d   = off[bgni_pkg::IdxW];
        mag_d   = off[bgni_pkg::IdxW] ? bgni_pkg::BaseW'(-off) : off[bgni_pkg::BaseW-1:0];
        cnt_d   = rdata_q.count;
        nr      = RW'(row_q) - RW'(SPAN_RADIUS);
        rd_en   = 1'b1;
        state_d = bgni_pkg::S_MUL;
      end
      bgni_pkg::S_MUL: begin
        basen_d   = rdata_q.base;
        div_start = 1'b1;
        state_d   = bgni_pkg::S_DIV;
      end
      bgni_pkg::S_DIV: begin
        if (div_done) begin
          state_d = bgni_pkg::S_ADD;
        end
      end
      bgni_pkg::S_ADD: begin
        sbase_d = $signed(SW'(basen_q)) + qs;
        j_d     = '0;
        state_d = bgni_pkg::S_EMIT;
      end
      bgni_pkg::S_EMIT: begin
        valid_d = 1'b1;
        out_d.grid_row  = i_q;
        out_d.grid_col  = j_q;
        out_d.in_center = (4'(i_q) + 4'd1 >= 4'(SPAN_RADIUS)) && (4'(i_q) <= 4'(SPAN_RADIUS + 1))
                       && (4'(j_q) + 4'd1 >= 4'(SPAN_RADIUS)) && (4'(j_q) <= 4'(SPAN_RADIUS + 1));
        if (idx < -$signed(SW'(64'd1) <<< (bgni_pkg::IdxW - 1))) begin
          out_d.neighbor_index = {1'b1, {(bgni_pkg::IdxW-1){1'b0}}};
        end else if (idx > $signed((SW'(64'd1) <<< (bgni_pkg::IdxW - 1)) - SW'(1))) begin
          out_d.neighbor_index = {1'b0, {(bgni_pkg::IdxW-1){1'b1}}};
        end else begin
          out_d.neighbor_index = idx[bgni_pkg::IdxW-1:0];
        end
        if (idx == -$signed(SW'(1))) begin
          out_d.status = bgni_pkg::ST_ABORT;
          out_d.last   = 1'b1;
          state_d      = bgni_pkg::S_IDLE;
        end else begin
          out_d.status = bgni_pkg::ST_OK;
          out_d.last   = (i_q == 3'(GS - 1)) && (j_q == 3'(GS - 1));
          if (j_q == 3'(GS - 1)) begin
            if (i_q == 3'(GS - 1)) begin
              state_d = bgni_pkg::S_IDLE;
            end else begin
              i_d     = i_q + 3'd1;
              j_d     = '0;
              nr      = RW'(row_q) + RW'(i_d) - RW'(SPAN_RADIUS);
              rd_en   = 1'b1;
              state_d = bgni_pkg::S_MUL;
            end
          end else begin
            j_d = j_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = bgni_pkg::S_IDLE;
      end
    endcase
    rd_addr = nr[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgni_pkg::S_IDLE;
      valid_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    bin_q   <= bin_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
    basen_q <= basen_d;
    sbase_q <= sbase_d;
    out_q   <= out_d;
  end

  assign busy_o         = state_q != bgni_pkg::S_IDLE;
  assign result_valid_o = valid_q;
  assign result_o       = out_q;

  // a run that is not finished keeps the sequencer busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("run left idle before its last word");

  // aborted and edge words always close the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == bgni_pkg::ST_ABORT
                       || result_o.status == bgni_pkg::ST_EDGE) |-> result_o.last)
    else $error("error word without last");

  // words come only from the emit step or an edge answer from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == bgni_pkg::S_EMIT || state_q == bgni_pkg::S_IDLE))
    else $error("word emitted from wrong state");

endmodule
